// ===== rtl/core/pfsieve_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsieve_pkg
// Shared constants and types for the smallest-prime-factor factorizer.
// ----------------------------------------------------------------------------
package pfsieve_pkg;

	// width of request values and result factors
	localparam int VAL_W    = 16;
	// sieve table depth and address width
	localparam int TBL_SIZE = 65536;
	localparam int TBL_AW   = $clog2(TBL_SIZE);
	// result guard per request
	localparam int MAX_RES  = 16;
	localparam int CNT_W    = $clog2(MAX_RES);

	// divide job handed to the shared divider
	typedef struct packed {
		logic [VAL_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/core/pfsieve_div.sv =====
// ----------------------------------------------------------------------------
// pfsieve_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfsieve_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  pfsieve_pkg::div_req_t          req,
	output logic                           done,
	output logic [pfsieve_pkg::VAL_W-1:0]  quotient
);
	import pfsieve_pkg::*;

	localparam int STEP_W = $clog2(VAL_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [VAL_W-1:0]  dvs_q;

	logic [VAL_W:0]    shifted;
	logic [VAL_W:0]    diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[VAL_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VAL_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[VAL_W-1:0];
			end else begin
				rem_q <= shifted[VAL_W-1:0];
			end
			quo_q <= {quo_q[VAL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/prime_factorizer_spf_sieve.sv =====
// ----------------------------------------------------------------------------
// prime_factorizer_spf_sieve
// Prime factorizer on a smallest-prime-factor table built by a sieve.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / value): one request per value.
//    in_stall is high while a request is being worked on.
//  - Output channel (out_valid / out_stall / factor / last): one result per
//    prime factor, nondecreasing, repeats included; last marks the final one.
//    Values 0 and 1 give one result, factor 0 with last set.
//  - The first request after reset fills the table: an init sweep
//    (entry i = i) over all TBL_SIZE entries, then the sieve, which reads
//    and tests each table entry visited. Later requests reuse the table.
//  - Steady state per factor: table read (F_RD), result load and divider
//    start (F_EMIT), then the wait for the shared bit-serial divider (16
//    quotient steps plus done); the final factor needs no divide. At most
//    15 factors for a 16-bit value.
//  - A finished result sits in the output register while the sequencer goes
//    on; if the receiver stalls, the sequencer waits before loading the next.
//  - Reset clears the sequencer and the table-ready flag; table contents are
//    not cleared and are rebuilt on the next first request.
// ----------------------------------------------------------------------------
module prime_factorizer_spf_sieve (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pfsieve_pkg::VAL_W-1:0]  value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pfsieve_pkg::VAL_W-1:0]  factor,
	output logic                           last
);
	import pfsieve_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,    // entry i = i sweep
		ST_SI_RD,   // read table[i]
		ST_SI_TST,  // is i prime?
		ST_SJ_RD,   // read table[j]
		ST_SJ_TST,  // mark j with i if still unmarked
		ST_CHECK,   // special values
		ST_F_RD,    // read table[v]
		ST_F_EMIT,  // load result, start divide
		ST_F_DIV    // wait for v / f
	} state_t;

	localparam logic [TBL_AW:0] SIZE_X = (TBL_AW+1)'(TBL_SIZE);

	state_t             state_q;
	logic               ready_q;     // table built
	logic [TBL_AW-1:0]  i_q;         // sieve prime candidate
	logic [TBL_AW:0]    sq_q;        // i * i
	logic [TBL_AW:0]    j_q;         // sieve multiple / init pointer
	logic [VAL_W-1:0]   v_q;         // remaining value
	logic [CNT_W-1:0]   cnt_q;       // results issued for this request
	logic               out_valid_q;
	logic [VAL_W-1:0]   factor_q;
	logic               last_q;

	// table memory
	logic [TBL_AW-1:0]  mem [TBL_SIZE];
	logic [TBL_AW-1:0]  rdata_q;
	logic [TBL_AW-1:0]  raddr;
	logic               we;
	logic [TBL_AW-1:0]  waddr;
	logic [TBL_AW-1:0]  wdata;

	// divider
	logic               div_start;
	div_req_t           div_req;
	logic               div_done;
	logic [VAL_W-1:0]   div_quo;

	logic               out_free;
	logic [TBL_AW-1:0]  f_raw;
	logic [VAL_W-1:0]   f_eff;
	logic               f_last;
	logic               v_special;
	logic [TBL_AW:0]    i_ext;

	assign out_free  = !out_valid_q || !out_stall;
	assign i_ext     = (TBL_AW+1)'(i_q);
	assign v_special = (v_q <= VAL_W'(1)) || (32'(v_q) >= 32'(TBL_SIZE));

	// entry below two never happens on a filled table; fall back to v
	assign f_raw  = rdata_q;
	assign f_eff  = (32'(f_raw) < 32'd2) ? v_q : VAL_W'(f_raw);
	assign f_last = (f_eff == v_q) || (cnt_q == CNT_W'(MAX_RES - 1));

	assign div_start        = (state_q == ST_F_EMIT) && out_free && !f_last;
	assign div_req.dividend = v_q;
	assign div_req.divisor  = f_eff;

	always_comb begin
		we    = 1'b0;
		waddr = j_q[TBL_AW-1:0];
		wdata = j_q[TBL_AW-1:0];
		case (state_q)
			ST_SI_RD:  raddr = i_q;
			ST_SJ_RD:  raddr = j_q[TBL_AW-1:0];
			default:   raddr = TBL_AW'(v_q);
		endcase
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
			end
			ST_SJ_TST: begin
				we    = (rdata_q == j_q[TBL_AW-1:0]);
				wdata = i_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	pfsieve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			i_q         <= '0;
			sq_q        <= '0;
			j_q         <= '0;
			v_q         <= '0;
			factor_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q   <= value;
						cnt_q <= '0;
						j_q   <= '0;
						state_q <= ready_q ? ST_CHECK : ST_INIT;
					end
				end
				ST_INIT: begin
					j_q <= j_q + (TBL_AW+1)'(1);
					if (j_q == SIZE_X - (TBL_AW+1)'(1)) begin
						i_q     <= TBL_AW'(2);
						sq_q    <= (TBL_AW+1)'(4);
						state_q <= ST_SI_RD;
					end
				end
				ST_SI_RD: begin
					if (sq_q >= SIZE_X) begin
						ready_q <= 1'b1;
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_SI_TST;
					end
				end
				ST_SI_TST: begin
					if (rdata_q == i_q) begin
						j_q     <= sq_q;
						state_q <= ST_SJ_RD;
					end else begin
						i_q     <= i_q + TBL_AW'(1);
						sq_q    <= sq_q + {i_q, 1'b1};
						state_q <= ST_SI_RD;
					end
				end
				ST_SJ_RD: begin
					if (j_q >= SIZE_X) begin
						i_q     <= i_q + TBL_AW'(1);
						sq_q    <= sq_q + {i_q, 1'b1};
						state_q <= ST_SI_RD;
					end else begin
						state_q <= ST_SJ_TST;
					end
				end
				ST_SJ_TST: begin
					j_q     <= j_q + i_ext;
					state_q <= ST_SJ_RD;
				end
				ST_CHECK: begin
					if (v_special) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							factor_q    <= '0;
							last_q      <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						state_q <= ST_F_RD;
					end
				end
				ST_F_RD: begin
					state_q <= ST_F_EMIT;
				end
				ST_F_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						factor_q    <= f_eff;
						last_q      <= f_last;
						cnt_q       <= cnt_q + CNT_W'(1);
						state_q     <= f_last ? ST_IDLE : ST_F_DIV;
					end
				end
				ST_F_DIV: begin
					if (div_done) begin
						v_q     <= div_quo;
						state_q <= ST_F_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign last      = last_q;

endmodule
